/* rtl/srsfe_pkg.sv */
`timescale 1ns / 1ps
package srsfe_pkg;

	localparam int FRAME_LEN_DEF   = 8;
	localparam int TX_LIMIT_DEF    = 32;
	localparam int STORE_DEPTH_DEF = 256;

	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [7:0]  END_MARK    = 8'h0A;
	localparam logic [7:0]  FN_READ     = 8'h03;
	localparam logic [7:0]  FN_WRITE    = 8'h06;
	localparam logic [7:0]  SUB_CAPTURE = 8'h03;
	localparam logic [7:0]  ADDR_RESET  = 8'h44;

	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_ERROR   = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  rx_byte;
		logic [31:0] capture_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} out_item_t;

	// reply kinds
	typedef enum logic [1:0] {
		RK_CAPTURE,
		RK_READ,
		RK_WRITE
	} reply_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE0,
		ST_WRITE1,
		ST_LOAD,
		ST_CRC,
		ST_SEND,
		ST_CRCLO,
		ST_CRCHI
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic        take;       // store frame byte / update index
		logic        start;      // latch capture, reset reply counter and CRC
		logic        write0;
		logic        write1;
		logic        load;       // fetch current reply byte into byte register
		logic        crc_step;   // one CRC bit
		logic        next_byte;  // advance reply counter
		logic        sel_crc_lo;
		logic        sel_crc_hi;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic        frame_done;  // accepted byte closed an addressed frame
		logic        reply_ok;
		reply_kind_t kind;
		logic        bit_last;
		logic        body_last;
	} stat_t;

endpackage

/* rtl/srsfe_ctrl.sv */
`timescale 1ns / 1ps
module srsfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_last,
	input  srsfe_pkg::stat_t  stat,
	output srsfe_pkg::ctrl_t  ctrl
);

	srsfe_pkg::state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srsfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		case (state_q)
			srsfe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.take = 1'b1;
					if (stat.frame_done && stat.reply_ok) begin
						ctrl.start = 1'b1;
						if (stat.kind == srsfe_pkg::RK_WRITE)
							state_d = srsfe_pkg::ST_WRITE0;
						else
							state_d = srsfe_pkg::ST_LOAD;
					end
				end
			end
			srsfe_pkg::ST_WRITE0: begin
				ctrl.write0 = 1'b1;
				state_d     = srsfe_pkg::ST_WRITE1;
			end
			srsfe_pkg::ST_WRITE1: begin
				ctrl.write1 = 1'b1;
				state_d     = srsfe_pkg::ST_LOAD;
			end
			srsfe_pkg::ST_LOAD: begin
				ctrl.load = 1'b1;
				state_d   = srsfe_pkg::ST_CRC;
			end
			srsfe_pkg::ST_CRC: begin
				ctrl.crc_step = 1'b1;
				if (stat.bit_last)
					state_d = srsfe_pkg::ST_SEND;
			end
			srsfe_pkg::ST_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					ctrl.next_byte = 1'b1;
					state_d = stat.body_last ? srsfe_pkg::ST_CRCLO : srsfe_pkg::ST_LOAD;
				end
			end
			srsfe_pkg::ST_CRCLO: begin
				out_valid      = 1'b1;
				ctrl.sel_crc_lo = 1'b1;
				if (out_ready)
					state_d = srsfe_pkg::ST_CRCHI;
			end
			srsfe_pkg::ST_CRCHI: begin
				out_valid      = 1'b1;
				out_last       = 1'b1;
				ctrl.sel_crc_hi = 1'b1;
				if (out_ready)
					state_d = srsfe_pkg::ST_IDLE;
			end
			default: state_d = srsfe_pkg::ST_IDLE;
		endcase
	end

endmodule

/* rtl/srsfe_dp.sv */
`timescale 1ns / 1ps
module srsfe_dp #(
	parameter int FRAME_LEN   = srsfe_pkg::FRAME_LEN_DEF,
	parameter int TX_LIMIT    = srsfe_pkg::TX_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           slave_address,
	input  srsfe_pkg::in_item_t  in_item,
	input  srsfe_pkg::ctrl_t     ctrl,
	output srsfe_pkg::stat_t     stat,
	output logic [7:0]           tx_byte
);

	localparam int STORE_DEPTH = srsfe_pkg::STORE_DEPTH_DEF;
	localparam int FIW = $clog2(FRAME_LEN + 1);
	localparam int FAW = $clog2(FRAME_LEN);
	localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int RCW = $clog2(TX_LIMIT + 1);

	logic [7:0]     frame_q [FRAME_LEN];
	logic [FIW-1:0] index_q;
	logic [7:0]     store_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [31:0]    cap_q;
	logic [RCW-1:0] pos_q;
	logic [RCW-1:0] len_q;
	logic [7:0]     byte_q;
	logic [15:0]    crc_q;
	logic [2:0]     bit_q;
	srsfe_pkg::reply_kind_t kind_q;
	logic           rd_valid_q;

	logic        is_byte, full, closes;
	logic [7:0]  fn, head;
	logic [8:0]  cnt;
	logic [SAW-1:0] base, rd_addr, wr_addr;
	logic [7:0]  rd_data, body, nxt_byte;
	logic [RCW-1:0] body_len;
	logic [15:0] crc_x;

	assign is_byte = in_item.req_type == srsfe_pkg::REQ_BYTE;
	assign full    = index_q == FIW'(FRAME_LEN);
	assign closes  = is_byte && !full && index_q == FIW'(FRAME_LEN - 1)
		&& in_item.rx_byte == srsfe_pkg::END_MARK;
	assign fn      = frame_q[1];
	assign head    = frame_q[0];
	assign cnt     = {frame_q[5], 1'b0};
	assign base    = SAW'(frame_q[3]);

	// decode the completed frame
	always_comb begin
		stat.frame_done = closes && head == slave_address;
		stat.reply_ok   = 1'b0;
		stat.kind       = srsfe_pkg::RK_READ;
		if (fn == srsfe_pkg::FN_READ) begin
			if (frame_q[2] == srsfe_pkg::SUB_CAPTURE) begin
				stat.kind     = srsfe_pkg::RK_CAPTURE;
				stat.reply_ok = 1'b1;
			end else begin
				stat.reply_ok = cnt <= 9'(TX_LIMIT - 5);
			end
		end else if (fn == srsfe_pkg::FN_WRITE) begin
			stat.kind     = srsfe_pkg::RK_WRITE;
			stat.reply_ok = 1'b1;
		end
		stat.bit_last  = bit_q == 3'd7;
		stat.body_last = pos_q == len_q - RCW'(1);
	end

	// collect request bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (ctrl.take) begin
			if (in_item.req_type == srsfe_pkg::REQ_ERROR
					|| in_item.req_type == srsfe_pkg::REQ_TIMEOUT)
				index_q <= '0;
			else if (is_byte && !full)
				index_q <= closes ? '0 : index_q + FIW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take && is_byte && !full)
			frame_q[index_q[FAW-1:0]] <= in_item.rx_byte;
	end

	// store: valid bits stand for the reset clear
	// fetch one position ahead so the data is ready at the next load
	assign wr_addr = ctrl.write1 ? base + SAW'(1) : base;
	assign rd_addr = base + SAW'(pos_q - RCW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.write0 || ctrl.write1) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.write0)
			store_q[wr_addr] <= frame_q[4];
		else if (ctrl.write1)
			store_q[wr_addr] <= frame_q[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= store_q[rd_addr];
	end

	// reply body byte at current position
	always_comb begin
		body = '0;
		body_len = RCW'(6);
		case (kind_q)
			srsfe_pkg::RK_CAPTURE: body_len = RCW'(7);
			srsfe_pkg::RK_READ:    body_len = RCW'(3) + RCW'(cnt);
			default:               body_len = RCW'(6);
		endcase
		if (pos_q == '0) begin
			body = slave_address;
		end else if (pos_q == RCW'(1)) begin
			body = fn;
		end else begin
			case (kind_q)
				srsfe_pkg::RK_CAPTURE: begin
					case (pos_q[2:0])
						3'd2:    body = 8'd4;
						3'd3:    body = cap_q[31:24];
						3'd4:    body = cap_q[23:16];
						3'd5:    body = cap_q[15:8];
						default: body = cap_q[7:0];
					endcase
				end
				srsfe_pkg::RK_READ: begin
					body = (pos_q == RCW'(2)) ? cnt[7:0] : 8'h00;
				end
				default: begin
					case (pos_q[2:0])
						3'd2:    body = frame_q[2];
						3'd3:    body = frame_q[3];
						3'd4:    body = frame_q[4];
						default: body = frame_q[5];
					endcase
				end
			endcase
		end
	end

	// pick store data for read payload, else the body byte
	always_comb begin
		if (kind_q == srsfe_pkg::RK_READ && pos_q >= RCW'(3))
			nxt_byte = rd_valid_q ? rd_data : 8'h00;
		else
			nxt_byte = body;
	end

	assign crc_x = crc_q[0] ? ((crc_q >> 1) ^ srsfe_pkg::CRC_POLY) : (crc_q >> 1);

	// reply sequencing and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			bit_q  <= '0;
			kind_q <= srsfe_pkg::RK_READ;
			crc_q  <= srsfe_pkg::CRC_INIT;
		end else begin
			if (ctrl.start) begin
				pos_q  <= '0;
				kind_q <= stat.kind;
				crc_q  <= srsfe_pkg::CRC_INIT;
			end
			if (ctrl.load) begin
				len_q <= body_len;
				bit_q <= '0;
				crc_q <= crc_q ^ {8'h00, nxt_byte};
			end
			if (ctrl.crc_step) begin
				crc_q <= crc_x;
				bit_q <= bit_q + 3'd1;
			end
			if (ctrl.next_byte)
				pos_q <= pos_q + RCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start)
			cap_q <= in_item.capture_value;
		if (ctrl.load)
			byte_q <= nxt_byte;
	end

	// output byte select
	always_comb begin
		if (ctrl.sel_crc_lo)
			tx_byte = crc_q[7:0];
		else if (ctrl.sel_crc_hi)
			tx_byte = crc_q[15:8];
		else
			tx_byte = byte_q;
	end

endmodule

/* rtl/serial_register_slave_frame_engine_top.sv */
`timescale 1ns / 1ps
// Request/reply frame engine for a serial register slave.
// Input channel (in_valid/in_ready/in_item): one beat per received byte,
// line error or receive timeout. Output channel (out_valid/out_ready/
// out_item): one beat per reply byte; last_byte marks the CRC high byte.
// cfg_we/cfg_wdata write the slave address; the user must do so only
// while idle, the block itself does not enforce this. A beat that does
// not close an addressed, supported request is taken while the engine
// stays idle. The closing beat of such a request starts a reply: a write
// request first updates the store in WRITE0 and WRITE1; then each reply
// body byte passes the LOAD, CRC (one bit per cycle) and SEND states, and
// the CRC bytes go out from CRCLO and CRCHI. The serial CRC sets the pace.
// No input beat is taken until the reply has gone out.
// When the receiver stalls, the current byte is held on the output.
// Reset clears the frame index, marks every store entry as zero and loads
// the slave address with 0x44; nothing else is needed before use.
module serial_register_slave_frame_engine_top #(
	parameter int FRAME_LEN   = srsfe_pkg::FRAME_LEN_DEF,
	parameter int TX_LIMIT    = srsfe_pkg::TX_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  srsfe_pkg::in_item_t   in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output srsfe_pkg::out_item_t  out_item
);

	logic [7:0]       addr_q;
	srsfe_pkg::ctrl_t ctrl;
	srsfe_pkg::stat_t stat;
	logic             last;
	logic [7:0]       tx;

	// hold the slave address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= srsfe_pkg::ADDR_RESET;
		end else if (cfg_we) begin
			addr_q <= cfg_wdata;
		end
	end

	srsfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_last  (last),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	srsfe_dp #(
		.FRAME_LEN   (FRAME_LEN),
		.TX_LIMIT    (TX_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_address (addr_q),
		.in_item       (in_item),
		.ctrl          (ctrl),
		.stat          (stat),
		.tx_byte       (tx)
	);

	assign out_item.tx_byte   = tx;
	assign out_item.last_byte = last;

	// no input beat while a reply is under way
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken during reply");

	// the final beat is followed by readiness for input
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.last_byte |=> in_ready)
		else $error("engine did not return to idle");

	// CRC steps never overlap a send
	a_crc_send: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.crc_step |-> !out_valid)
		else $error("CRC step during send");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import srsfe_pkg::*;

	localparam int FRAME_LEN   = FRAME_LEN_DEF;
	localparam int TX_LIMIT    = TX_LIMIT_DEF;
	localparam int STORE_DEPTH = STORE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1500000;

	// Reply predictor with its own copy of the frame state and store
	class reply_scoreboard;
		logic [7:0]  addr;
		logic [7:0]  frame [FRAME_LEN];
		int          fill;
		logic [7:0]  store [STORE_DEPTH];
		out_item_t   pending [$];
		int          errors;
		int          replies;

		function new();
			addr = ADDR_RESET;
			fill = 0;
			errors = 0;
			replies = 0;
			foreach (store[i]) store[i] = 8'h00;
		endfunction

		function void push_reply(logic [7:0] body [$]);
			logic [15:0] crc;
			out_item_t   r;
			crc = CRC_INIT;
			foreach (body[i]) begin
				crc = crc ^ {8'h00, body[i]};
				for (int b = 0; b < 8; b++)
					crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
			body.push_back(crc[7:0]);
			body.push_back(crc[15:8]);
			foreach (body[i]) begin
				r.tx_byte = body[i];
				r.last_byte = (i == body.size() - 1);
				pending.push_back(r);
			end
			replies++;
		endfunction

		function void note_input(in_item_t it);
			logic [7:0] body [$];
			int         cnt;
			if (it.req_type == REQ_ERROR || it.req_type == REQ_TIMEOUT) begin
				fill = 0;
				return;
			end
			if (it.req_type != REQ_BYTE || fill >= FRAME_LEN)
				return;
			frame[fill] = it.rx_byte;
			fill++;
			if (fill != FRAME_LEN || it.rx_byte != END_MARK)
				return;
			fill = 0;
			if (frame[0] != addr)
				return;
			body.push_back(addr);
			body.push_back(frame[1]);
			if (frame[1] == FN_READ && frame[2] == SUB_CAPTURE) begin
				body.push_back(8'd4);
				for (int k = 3; k >= 0; k--)
					body.push_back(it.capture_value[8*k +: 8]);
				push_reply(body);
			end else if (frame[1] == FN_READ) begin
				cnt = 2 * int'(frame[5]);
				if (cnt > TX_LIMIT - 5)
					return;
				body.push_back(cnt[7:0]);
				for (int k = 0; k < cnt; k++)
					body.push_back(store[(int'(frame[3]) + k) % STORE_DEPTH]);
				push_reply(body);
			end else if (frame[1] == FN_WRITE) begin
				store[int'(frame[3]) % STORE_DEPTH] = frame[4];
				store[(int'(frame[3]) + 1) % STORE_DEPTH] = frame[5];
				for (int k = 2; k <= 5; k++)
					body.push_back(frame[k]);
				push_reply(body);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat tx_byte=%02h last_byte=%0b", $time,
					got.tx_byte, got.last_byte);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.tx_byte !== want.tx_byte) begin
				$display("%0t: tx_byte expected %02h actual %02h", $time,
					want.tx_byte, got.tx_byte);
				errors++;
			end
			if (got.last_byte !== want.last_byte) begin
				$display("%0t: last_byte expected %0b actual %0b", $time,
					want.last_byte, got.last_byte);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;

	reply_scoreboard sb;
	int          cycles;
	int          stall_mode;
	int          gap_max;
	logic [7:0]  cur_addr;

	serial_register_slave_frame_engine_top #(
		.FRAME_LEN  (FRAME_LEN),
		.TX_LIMIT   (TX_LIMIT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter and timeout
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("serial_register_slave_frame_engine_top verification failed");
				$finish;
			end
		end
	end

	// Receiver: stall on a changing pattern, check each accepted beat
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(out_item);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= cycles[2];
			endcase
		end
	end

	// Input: one beat, held until accepted, then at times a random gap
	task automatic send_beat(in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		gap = (gap_max == 0 || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(logic [7:0] b, logic [31:0] cap = $urandom());
		in_item_t it;
		it.req_type = REQ_BYTE;
		it.rx_byte = b;
		it.capture_value = cap;
		send_beat(it);
	endtask

	task automatic send_event(logic [1:0] kind);
		in_item_t it;
		it.req_type = kind;
		it.rx_byte = $urandom();
		it.capture_value = $urandom();
		send_beat(it);
	endtask

	task automatic send_frame(logic [7:0] a, logic [7:0] fn, logic [7:0] sub,
		logic [7:0] start, logic [7:0] d0, logic [7:0] d1, logic [31:0] cap = $urandom());
		send_byte(a);
		send_byte(fn);
		send_byte(sub);
		send_byte(start);
		send_byte(d0);
		send_byte(d1);
		send_byte($urandom());
		send_byte(END_MARK, cap);
	endtask

	// Drain all replies and allow for trailing work before the address is written
	task automatic drain_idle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_address(logic [7:0] a);
		drain_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.addr = a;
		cur_addr = a;
	endtask

	task automatic random_frame();
		logic [7:0] fn;
		logic [7:0] n;
		int         pick;
		pick = $urandom_range(0, 9);
		fn = (pick < 4) ? FN_READ : (pick < 8) ? FN_WRITE : $urandom();
		n = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 14);
		send_frame(($urandom_range(0, 9) == 0) ? $urandom() : cur_addr, fn,
			($urandom_range(0, 2) == 0) ? SUB_CAPTURE : $urandom(),
			($urandom_range(0, 3) == 0) ? $urandom_range(250, 255) : $urandom_range(0, 15),
			$urandom(), n);
	endtask

	task automatic random_noise();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			send_byte(($urandom_range(0, 2) == 0) ? END_MARK : $urandom());
		else if (pick < 7)
			send_event(REQ_ERROR);
		else if (pick < 9)
			send_event(REQ_TIMEOUT);
		else
			send_event(2'd3);
	endtask

	initial begin
		sb = new();
		stall_mode = 0;
		gap_max = 0;
		cur_addr = ADDR_RESET;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		in_valid = 1'b0;
		in_item = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: capture read, store writes and reads, edge cases
		send_frame(ADDR_RESET, FN_READ, SUB_CAPTURE, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
		send_frame(ADDR_RESET, FN_READ, SUB_CAPTURE, 8'hFF, 8'hFF, 8'hFF, 32'h0000_0000);
		send_frame(ADDR_RESET, FN_WRITE, 8'hFF, 8'hFF, 8'hA5, 8'h5A);
		send_frame(ADDR_RESET, FN_READ, 8'h00, 8'hFE, 8'h00, 8'd2);
		send_frame(ADDR_RESET, FN_READ, 8'h00, 8'h00, 8'h00, 8'd13);
		send_frame(ADDR_RESET, FN_READ, 8'h00, 8'h00, 8'h00, 8'd14);
		send_frame(ADDR_RESET, FN_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_frame(ADDR_RESET, FN_READ, 8'h00, 8'h00, 8'h00, 8'd0);
		send_frame(ADDR_RESET, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00);
		send_frame(8'h45, FN_WRITE, 8'h00, 8'h00, 8'h11, 8'h22);
		// Full frame without end mark stays full; bytes dropped until an error
		repeat (10) send_byte(8'h44);
		send_event(REQ_ERROR);
		send_byte(ADDR_RESET);
		send_event(REQ_TIMEOUT);
		send_event(2'd3);

		// Several addresses including the extremes
		for (int phase = 0; phase < 6; phase++) begin
			set_address(phase == 0 ? 8'h00 : phase == 1 ? 8'hFF :
				phase == 5 ? ADDR_RESET : $urandom());
			stall_mode = phase % 4;
			gap_max = (phase % 3 == 0) ? 0 : 6;
			for (int f = 0; f < 7; f++) begin
				if ($urandom_range(0, 3) == 0)
					random_noise();
				random_frame();
			end
			// Hold the sender until every reply has arrived
			if (phase == 2) begin
				in_valid <= 1'b0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0)
			$display("serial_register_slave_frame_engine_top verification clean");
		else
			$display("serial_register_slave_frame_engine_top verification failed");
		$finish;
	end
endmodule
